/* sv/qtt_pkg.sv */
// ----------------------------------------------------------------------------
// qtt_pkg: shared types and constants of the query text tokenizer
// Character codes, token kinds and the result record passed between modules.
// ----------------------------------------------------------------------------
package qtt_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 3;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // token kinds
    localparam logic [2:0] K_WORD    = 3'd0;
    localparam logic [2:0] K_INT     = 3'd1;
    localparam logic [2:0] K_DEC     = 3'd2;
    localparam logic [2:0] K_SPECIAL = 3'd3;
    localparam logic [2:0] K_STRING  = 3'd4;
    localparam logic [2:0] K_BADNUM  = 3'd5;
    localparam logic [2:0] K_UNTERM  = 3'd6;
    localparam logic [2:0] K_END     = 3'd7;

    // character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // one result item
    typedef struct packed {
        logic [62:0] value;
        logic [7:0]  code;
        logic [15:0] length;
        logic [15:0] start;
        logic [2:0]  kind;
        logic        done;
    } t_token;

    // up to two results caused by one byte
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token tok0;
        t_token tok1;
    } t_lex_out;

endpackage

/* sv/qtt_lex_core.sv */
// ----------------------------------------------------------------------------
// qtt_lex_core: tokenizer state and per-byte classification
// Consumes one byte per fire and produces zero, one or two result tokens.
// ----------------------------------------------------------------------------
module qtt_lex_core #(
    parameter int POS_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_ch,
    input  logic               i_last,
    output qtt_pkg::t_lex_out  o_res
);

    localparam int XW = POS_BITS + 1;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_STR  = 2'd2;
    localparam logic [1:0] MODE_HALT = 2'd3;

    typedef struct packed {
        logic        all_num;
        logic        dot;
        logic        digit;
        logic [62:0] accum;
        logic        over;
    } t_word;

    localparam t_word WORD_FRESH = '{all_num: 1'b1, dot: 1'b0, digit: 1'b0,
                                     accum: 63'd0, over: 1'b0};

    // fold one byte into the word being collected
    function automatic t_word absorb(input t_word w, input logic [7:0] c);
        t_word       r;
        logic [66:0] t10;
        r   = w;
        t10 = ({4'b0, w.accum} << 3) + ({4'b0, w.accum} << 1) + 67'(c - qtt_pkg::CH_ZERO);
        if (c >= qtt_pkg::CH_ZERO && c <= qtt_pkg::CH_NINE) begin
            r.digit = 1'b1;
            if (!w.over) begin
                if (|t10[66:63]) begin
                    r.over = 1'b1;
                end else begin
                    r.accum = t10[62:0];
                end
            end
        end else if (c == qtt_pkg::CH_DOT) begin
            if (w.dot) begin
                r.all_num = 1'b0;
            end
            r.dot = 1'b1;
        end else begin
            r.all_num = 1'b0;
        end
        return r;
    endfunction

    // kind of a finished word
    function automatic logic [2:0] close_kind(input t_word w);
        logic [2:0] k;
        if (!w.all_num) begin
            k = qtt_pkg::K_WORD;
        end else if (w.dot) begin
            k = w.digit ? qtt_pkg::K_DEC : qtt_pkg::K_BADNUM;
        end else if (w.over) begin
            k = qtt_pkg::K_BADNUM;
        end else begin
            k = qtt_pkg::K_INT;
        end
        return k;
    endfunction

    // clamp a position or length to the 16-bit output field
    function automatic logic [15:0] sat16(input logic [XW-1:0] v);
        return (v > XW'(17'h0FFFF)) ? 16'hFFFF : 16'(v);
    endfunction

    // finished word as a token
    function automatic qtt_pkg::t_token word_tok(input t_word w,
                                                 input logic [15:0] st,
                                                 input logic [15:0] ln);
        qtt_pkg::t_token t;
        t        = '0;
        t.kind   = close_kind(w);
        t.start  = st;
        t.length = ln;
        t.value  = (t.kind == qtt_pkg::K_INT) ? w.accum : 63'd0;
        return t;
    endfunction

    logic [1:0]          r_mode,  n_mode;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [POS_BITS-1:0] r_begin, n_begin;
    logic [7:0]          r_quote, n_quote;
    t_word               r_word,  n_word;

    logic is_blank, is_special, is_qmark, is_delim;
    logic [XW-1:0] len_in, len_ex;
    logic [15:0]   st_p, st_b;
    t_word         word_new, word_one;

    // idle-byte outcome, shared by the idle case and the word-close case
    logic                idle_v;
    qtt_pkg::t_token     idle_tok;
    logic [1:0]          idle_mode;
    logic [POS_BITS-1:0] idle_begin;
    logic [7:0]          idle_quote;

    qtt_pkg::t_lex_out res;

    // byte classification
    always_comb begin
        is_blank   = (i_ch == qtt_pkg::CH_SPACE) || (i_ch == qtt_pkg::CH_NL) ||
                     (i_ch == qtt_pkg::CH_TAB);
        is_special = (i_ch == qtt_pkg::CH_LPAREN) || (i_ch == qtt_pkg::CH_RPAREN) ||
                     (i_ch == qtt_pkg::CH_LT)     || (i_ch == qtt_pkg::CH_GT)     ||
                     (i_ch == qtt_pkg::CH_LBRACE) || (i_ch == qtt_pkg::CH_RBRACE) ||
                     (i_ch == qtt_pkg::CH_LBRACK) || (i_ch == qtt_pkg::CH_RBRACK) ||
                     (i_ch == qtt_pkg::CH_COMMA);
        is_qmark   = (i_ch == qtt_pkg::CH_DQUOTE) || (i_ch == qtt_pkg::CH_SQUOTE);
        is_delim   = is_blank || is_special || is_qmark;
    end

    // positions and lengths
    always_comb begin
        len_ex   = XW'(r_pos) - XW'(r_begin);
        len_in   = len_ex + XW'(1);
        st_p     = sat16(XW'(r_pos));
        st_b     = sat16(XW'(r_begin));
        word_new = absorb(r_word, i_ch);
        word_one = absorb(WORD_FRESH, i_ch);
    end

    // byte arriving with no token open
    always_comb begin
        idle_v     = 1'b0;
        idle_tok   = '0;
        idle_mode  = MODE_IDLE;
        idle_begin = r_begin;
        idle_quote = r_quote;
        if (is_blank) begin
            idle_mode = MODE_IDLE;
        end else if (is_special) begin
            idle_v          = 1'b1;
            idle_tok.kind   = qtt_pkg::K_SPECIAL;
            idle_tok.start  = st_p;
            idle_tok.length = 16'd1;
            idle_tok.code   = i_ch;
        end else if (is_qmark) begin
            idle_mode  = MODE_STR;
            idle_begin = r_pos;
            idle_quote = i_ch;
            if (i_last) begin
                idle_v          = 1'b1;
                idle_tok.kind   = qtt_pkg::K_UNTERM;
                idle_tok.start  = st_p;
                idle_tok.length = 16'd1;
            end
        end else begin
            idle_mode  = MODE_WORD;
            idle_begin = r_pos;
            if (i_last) begin
                idle_v   = 1'b1;
                idle_tok = word_tok(word_one, st_p, 16'd1);
            end
        end
    end

    // main token decision and next state
    always_comb begin
        res     = '0;
        n_mode  = r_mode;
        n_begin = r_begin;
        n_quote = r_quote;
        n_word  = r_word;
        n_pos   = (r_pos < POS_MAX) ? r_pos + POS_BITS'(1) : POS_MAX;
        case (r_mode)
            MODE_STR: begin
                if (i_ch == r_quote) begin
                    res.v0          = 1'b1;
                    res.tok0.kind   = qtt_pkg::K_STRING;
                    res.tok0.start  = st_b;
                    res.tok0.length = sat16(len_in);
                    n_mode          = MODE_IDLE;
                end else if (i_last) begin
                    res.v0          = 1'b1;
                    res.tok0.kind   = qtt_pkg::K_UNTERM;
                    res.tok0.start  = st_b;
                    res.tok0.length = sat16(len_in);
                end
            end
            MODE_WORD: begin
                if (is_delim) begin
                    res.v0   = 1'b1;
                    res.tok0 = word_tok(r_word, st_b, sat16(len_ex));
                    if (res.tok0.kind == qtt_pkg::K_BADNUM) begin
                        n_mode = MODE_HALT;
                    end else begin
                        res.v1   = idle_v;
                        res.tok1 = idle_tok;
                        n_mode   = idle_mode;
                        n_begin  = idle_begin;
                        n_quote  = idle_quote;
                        n_word   = word_one;
                    end
                end else begin
                    n_word = word_new;
                    if (i_last) begin
                        res.v0   = 1'b1;
                        res.tok0 = word_tok(word_new, st_b, sat16(len_in));
                    end
                end
            end
            MODE_HALT: begin
                n_mode = MODE_HALT;
            end
            default: begin
                res.v0   = idle_v;
                res.tok0 = idle_tok;
                n_mode   = idle_mode;
                n_begin  = idle_begin;
                n_quote  = idle_quote;
                n_word   = word_one;
            end
        endcase

        // end of text: mark the final result and start over
        if (i_last) begin
            if (!res.v0) begin
                res.v0        = 1'b1;
                res.tok0.kind = qtt_pkg::K_END;
            end
            if (res.v1) begin
                res.tok1.done = 1'b1;
            end else begin
                res.tok0.done = 1'b1;
            end
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_begin = '0;
            n_quote = '0;
            n_word  = WORD_FRESH;
        end
    end

    assign o_res = i_fire ? res : '0;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_quote <= '0;
            r_word  <= WORD_FRESH;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_quote <= n_quote;
            r_word  <= n_word;
        end
    end

    // a second result only follows a first one
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.v1 |-> o_res.v0)
        else $error("second result without a first");

    // the last byte always leaves the position at zero
    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> (r_pos == '0 && r_mode == MODE_IDLE))
        else $error("state not cleared after last byte");

    // while halted only the end token comes out
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_mode == MODE_HALT) |->
        (!o_res.v1 && (!o_res.v0 || o_res.tok0.kind == qtt_pkg::K_END)))
        else $error("token emitted while halted");

endmodule

/* sv/qtt_result_fifo.sv */
// ----------------------------------------------------------------------------
// qtt_result_fifo: four-entry result queue
// Takes up to two tokens per cycle and presents one token per transfer.
// ----------------------------------------------------------------------------
module qtt_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qtt_pkg::t_lex_out  i_push,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output qtt_pkg::t_token    o_tok
);

    qtt_pkg::t_token r_mem [qtt_pkg::FIFO_DEPTH];

    logic [qtt_pkg::FIFO_AW-1:0] r_wr, n_wr;
    logic [qtt_pkg::FIFO_AW-1:0] r_rd, n_rd;
    logic [qtt_pkg::FIFO_CW-1:0] r_count, n_count;
    logic [qtt_pkg::FIFO_AW-1:0] wr1;
    logic [qtt_pkg::FIFO_CW-1:0] n_push;
    logic                        pop_ok;

    // pointer and count update
    always_comb begin
        pop_ok  = i_pop && (r_count != '0);
        n_push  = qtt_pkg::FIFO_CW'(i_push.v0) + qtt_pkg::FIFO_CW'(i_push.v1);
        wr1     = r_wr + qtt_pkg::FIFO_AW'(1);
        n_wr    = r_wr + qtt_pkg::FIFO_AW'(n_push);
        n_rd    = r_rd + qtt_pkg::FIFO_AW'(pop_ok);
        n_count = r_count + n_push - qtt_pkg::FIFO_CW'(pop_ok);
    end

    assign o_room  = (r_count <= qtt_pkg::FIFO_CW'(qtt_pkg::FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.v1) begin
            r_mem[wr1] <= i_push.tok1;
        end
    end

    // the queue never holds more than its depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= qtt_pkg::FIFO_CW'(qtt_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // a push only lands when room was reported
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> o_room)
        else $error("push without room");

    // a stalled head token keeps its place
    a_head_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop) |=> (r_rd == $past(r_rd)))
        else $error("head moved without a pop");

endmodule

/* sv/query_text_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// query_text_tokenizer_unit: streaming lexical tokenizer for query text
// Splits a byte stream into words, numbers, specials and strings.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per transfer in tdata[7:0]; tlast marks the
//   final byte of a text. Master stream: one token per transfer, its kind in
//   tuser; tlast is set on the final token caused by the final byte.
//   A byte is held in an input register, classified once the queue has
//   room and its tokens (none, one or two) are written to a four-entry
//   result queue. Throughput is one byte per cycle while the queue has
//   room; a byte that closes a word and is itself a special character or
//   a final quote yields two tokens. The classify step takes a byte only
//   when the queue has room for two tokens, so a stalled receiver fills
//   the queue and then the input register, after which tready drops.
//   Reset empties the queue and input register and starts a new text at
//   offset zero; the final byte of a text restarts the offset at zero too.
//   An error token (bad number) makes the unit drop bytes until tlast.
// ----------------------------------------------------------------------------
module query_text_tokenizer_unit #(
    parameter int POS_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [qtt_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // [7:0] ch
    input  logic                                i_s_axis_tlast,  // last
    // master stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] token_start, [31:16] token_length, [39:32] special_code,
    // [102:40] int_value, [103] zero
    output logic [qtt_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic [qtt_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser,  // [2:0] token_kind
    output logic                                o_m_axis_tlast   // done_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_ch;
    logic              r_in_last;
    logic              fire;
    logic              room;
    qtt_pkg::t_lex_out lex_res;
    qtt_pkg::t_token   head;

    assign fire            = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || room;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_ch   <= i_s_axis_tdata[7:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    // classification and token state
    qtt_lex_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (r_in_ch),
        .i_last  (r_in_last),
        .o_res   (lex_res)
    );

    // result queue
    qtt_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lex_res),
        .i_pop   (i_m_axis_tready),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_tok   (head)
    );

    // output packing
    assign o_m_axis_tdata = {1'b0, head.value, head.code, head.length, head.start};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.done;

endmodule

/* tb/sv/tb_query_text_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// tb_query_text_tokenizer_unit: self-checking bench for the query tokenizer
// Streams query texts one byte per transfer and predicts every token.
// A short table of hand-picked bytes comes first, then random texts.
// Both stream sides idle at random; each token is compared field by field
// against the predicted queue.
// ----------------------------------------------------------------------------
module tb_query_text_tokenizer_unit;

    localparam logic [63:0] INT63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;
    localparam int          RAND_BYTES = 425;

    localparam logic [7:0] SPECIAL_CHARS [9] = '{qtt_pkg::CH_LPAREN, qtt_pkg::CH_RPAREN,
        qtt_pkg::CH_LT, qtt_pkg::CH_GT, qtt_pkg::CH_LBRACE, qtt_pkg::CH_RBRACE,
        qtt_pkg::CH_LBRACK, qtt_pkg::CH_RBRACK, qtt_pkg::CH_COMMA};
    localparam logic [7:0] BLANK_CHARS [3] = '{qtt_pkg::CH_SPACE, qtt_pkg::CH_TAB,
        qtt_pkg::CH_NL};

    typedef enum logic [1:0] {LX_IDLE, LX_WORD, LX_STRING, LX_HALT} t_lex_mode;

    // one row of the hand-written stimulus table
    typedef struct {
        logic [7:0]      ch;
        logic            last;
        bit              typed;
        qtt_pkg::t_token tok;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [qtt_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [qtt_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [qtt_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic                            m_tlast;

    // tokenizer state as predicted
    t_lex_mode   lx_mode;
    logic [15:0] byte_pos;
    logic [15:0] tok_begin;
    logic [7:0]  open_quote;
    logic        all_numeric;
    logic        dot_seen;
    logic        digit_seen;
    logic [63:0] accum;
    logic        accum_over;

    // tokens caused by the byte just accepted
    qtt_pkg::t_token byte_tokens [2];
    int              n_byte_tokens;

    qtt_pkg::t_token expected_tokens [$];
    logic [7:0]      text_q [$];
    t_dir_row        dir_rows [24];

    bit          stall_en = 1'b1;
    int          fail_count;
    int          bytes_sent;
    int          texts_sent;
    int          tokens_checked;
    int          kind_hits [8];

    query_text_tokenizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // character classes
    function automatic bit is_special(input logic [7:0] c);
        return c == qtt_pkg::CH_LPAREN || c == qtt_pkg::CH_RPAREN ||
               c == qtt_pkg::CH_LT || c == qtt_pkg::CH_GT ||
               c == qtt_pkg::CH_LBRACE || c == qtt_pkg::CH_RBRACE ||
               c == qtt_pkg::CH_LBRACK || c == qtt_pkg::CH_RBRACK ||
               c == qtt_pkg::CH_COMMA;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == qtt_pkg::CH_SPACE || c == qtt_pkg::CH_TAB || c == qtt_pkg::CH_NL;
    endfunction

    function automatic bit is_qmark(input logic [7:0] c);
        return c == qtt_pkg::CH_DQUOTE || c == qtt_pkg::CH_SQUOTE;
    endfunction

    // token record with the length clipped to 16 bits
    function automatic qtt_pkg::t_token make_token(input logic [2:0] kind,
                                                   input logic [15:0] start,
                                                   input logic [16:0] len,
                                                   input logic [7:0] code,
                                                   input logic [62:0] val,
                                                   input logic done);
        qtt_pkg::t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
        t.code   = code;
        t.value  = val;
        t.done   = done;
        return t;
    endfunction

    task automatic add_token(input logic [2:0] kind, input logic [15:0] start,
                             input logic [16:0] len, input logic [7:0] code,
                             input logic [62:0] val);
        byte_tokens[n_byte_tokens] = make_token(kind, start, len, code, val, 1'b0);
        n_byte_tokens++;
    endtask

    // append one byte to the text being built
    task automatic text_add(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic lex_reset();
        lx_mode     = LX_IDLE;
        byte_pos    = '0;
        tok_begin   = '0;
        open_quote  = '0;
        all_numeric = 1'b1;
        dot_seen    = 1'b0;
        digit_seen  = 1'b0;
        accum       = '0;
        accum_over  = 1'b0;
    endtask

    // fold one byte into the open word
    task automatic word_absorb(input logic [7:0] c);
        logic [63:0] d;
        if (c >= qtt_pkg::CH_ZERO && c <= qtt_pkg::CH_NINE) begin
            d = {56'd0, c - qtt_pkg::CH_ZERO};
            digit_seen = 1'b1;
            if (!accum_over) begin
                if (accum > (INT63_MAX - d) / 64'd10) begin
                    accum_over = 1'b1;
                end else begin
                    accum = accum * 64'd10 + d;
                end
            end
        end else if (c == qtt_pkg::CH_DOT) begin
            if (dot_seen) begin
                all_numeric = 1'b0;
            end
            dot_seen = 1'b1;
        end else begin
            all_numeric = 1'b0;
        end
    endtask

    task automatic word_begin(input logic [15:0] p, input logic [7:0] c);
        lx_mode     = LX_WORD;
        tok_begin   = p;
        all_numeric = 1'b1;
        dot_seen    = 1'b0;
        digit_seen  = 1'b0;
        accum       = '0;
        accum_over  = 1'b0;
        word_absorb(c);
    endtask

    // classify the finished word; ok is low on a bad number
    task automatic word_close(input logic [16:0] len, output bit ok);
        ok = 1'b1;
        if (!all_numeric) begin
            add_token(qtt_pkg::K_WORD, tok_begin, len, 8'd0, 63'd0);
        end else if (dot_seen) begin
            if (!digit_seen) begin
                add_token(qtt_pkg::K_BADNUM, tok_begin, len, 8'd0, 63'd0);
                ok = 1'b0;
            end else begin
                add_token(qtt_pkg::K_DEC, tok_begin, len, 8'd0, 63'd0);
            end
        end else if (accum_over) begin
            add_token(qtt_pkg::K_BADNUM, tok_begin, len, 8'd0, 63'd0);
            ok = 1'b0;
        end else begin
            add_token(qtt_pkg::K_INT, tok_begin, len, 8'd0, accum[62:0]);
        end
    endtask

    // byte seen while no token is open
    task automatic idle_byte(input logic [15:0] p, input logic [7:0] c, input logic last);
        bit ok;
        if (is_blank(c)) begin
            lx_mode = LX_IDLE;
        end else if (is_special(c)) begin
            lx_mode = LX_IDLE;
            add_token(qtt_pkg::K_SPECIAL, p, 17'd1, c, 63'd0);
        end else if (is_qmark(c)) begin
            lx_mode    = LX_STRING;
            tok_begin  = p;
            open_quote = c;
            if (last) begin
                add_token(qtt_pkg::K_UNTERM, p, 17'd1, 8'd0, 63'd0);
            end
        end else begin
            word_begin(p, c);
            if (last) begin
                word_close(17'd1, ok);
            end
        end
    endtask

    // predict the tokens caused by one accepted byte
    task automatic tokenize_byte(input logic [7:0] c, input logic last);
        logic [15:0] p;
        logic [16:0] span;
        bit          ok;
        p    = byte_pos;
        span = {1'b0, p} - {1'b0, tok_begin};
        n_byte_tokens = 0;
        case (lx_mode)
            LX_STRING: begin
                if (c == open_quote) begin
                    add_token(qtt_pkg::K_STRING, tok_begin, span + 17'd1, 8'd0, 63'd0);
                    lx_mode = LX_IDLE;
                end else if (last) begin
                    add_token(qtt_pkg::K_UNTERM, tok_begin, span + 17'd1, 8'd0, 63'd0);
                end
            end
            LX_WORD: begin
                if (is_blank(c) || is_special(c) || is_qmark(c)) begin
                    word_close(span, ok);
                    if (ok) begin
                        lx_mode = LX_IDLE;
                        idle_byte(p, c, last);
                    end else begin
                        lx_mode = LX_HALT;
                    end
                end else begin
                    word_absorb(c);
                    if (last) begin
                        word_close(span + 17'd1, ok);
                    end
                end
            end
            LX_HALT: begin
            end
            default: begin
                idle_byte(p, c, last);
            end
        endcase
        if (n_byte_tokens > 0 &&
            byte_tokens[n_byte_tokens-1].kind == qtt_pkg::K_BADNUM) begin
            lx_mode = LX_HALT;
        end
        if (last) begin
            if (n_byte_tokens == 0) begin
                add_token(qtt_pkg::K_END, 16'd0, 17'd0, 8'd0, 63'd0);
            end
            byte_tokens[n_byte_tokens-1].done = 1'b1;
            lex_reset();
        end else if (byte_pos != POS_MAX) begin
            byte_pos = byte_pos + 16'd1;
        end
    endtask

    // offer one byte, wait for its transfer, then record what it causes
    task automatic send_byte(input logic [7:0] c, input logic last, input bit use_typed,
                             input qtt_pkg::t_token typed_tok);
        int i;
        if (stall_en && $urandom_range(0, 99) < 3) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        tokenize_byte(c, last);
        if (use_typed) begin
            expected_tokens = {expected_tokens, typed_tok};
        end else begin
            for (i = 0; i < n_byte_tokens; i++) begin
                expected_tokens = {expected_tokens, byte_tokens[i]};
            end
        end
        bytes_sent++;
        if (last) begin
            texts_sent++;
        end
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
        end
    endtask

    // hold the sender until every predicted token has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    // random text: mostly well-formed tokens, some broken ones and noise
    task automatic build_text();
        int         n_tok;
        int         j;
        int         k;
        int         sel;
        logic [7:0] q;
        string      lit;
        text_q.delete();
        n_tok = $urandom_range(1, 8);
        for (j = 0; j < n_tok; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 22) begin
                // short integer
                repeat ($urandom_range(1, 6))
                    text_add(qtt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (sel < 27) begin
                // integers at and past the 63-bit limit
                case ($urandom_range(0, 2))
                    0: lit = "9223372036854775807";
                    1: lit = "9223372036854775808";
                    default: lit = "99999999999999999999";
                endcase
                for (k = 0; k < lit.len(); k++) begin
                    text_add(lit[k]);
                end
            end else if (sel < 37) begin
                // decimal, sometimes a lone dot or a second dot
                repeat ($urandom_range(0, 3))
                    text_add(qtt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                text_add(qtt_pkg::CH_DOT);
                repeat ($urandom_range(0, 3))
                    text_add(qtt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 9) == 0) begin
                    text_add(qtt_pkg::CH_DOT);
                end
            end else if (sel < 55) begin
                // plain word of letters and high bytes
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        text_add(8'($urandom_range(128, 255)));
                    end else begin
                        text_add(8'($urandom_range(8'h61, 8'h7A)));
                    end
                end
            end else if (sel < 72) begin
                text_add(SPECIAL_CHARS[$urandom_range(0, 8)]);
            end else if (sel < 90) begin
                // quoted string, now and then left open
                q = $urandom_range(0, 1) ? qtt_pkg::CH_DQUOTE : qtt_pkg::CH_SQUOTE;
                text_add(q);
                repeat ($urandom_range(0, 5)) begin
                    k = $urandom_range(0, 255);
                    text_add((8'(k) == q) ? qtt_pkg::CH_DOT : 8'(k));
                end
                if ($urandom_range(0, 7) != 0) begin
                    text_add(q);
                end
            end else begin
                // noise
                repeat ($urandom_range(1, 3)) text_add(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 6) begin
                text_add(BLANK_CHARS[$urandom_range(0, 2)]);
            end
        end
    endtask

    // token checker and receiver backpressure
    always @(posedge i_clk) begin : token_monitor
        qtt_pkg::t_token want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token transfer, tdata %h tuser %h tlast %b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (m_tuser != want.kind) begin
                    $error("token_kind: expected %0d, actual %0d", want.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata[15:0] != want.start) begin
                    $error("token_start: expected %0d, actual %0d", want.start, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[31:16] != want.length) begin
                    $error("token_length: expected %0d, actual %0d", want.length,
                           m_tdata[31:16]);
                    fail_count++;
                end
                if (m_tdata[39:32] != want.code) begin
                    $error("special_code: expected %h, actual %h", want.code, m_tdata[39:32]);
                    fail_count++;
                end
                if (m_tdata[102:40] != want.value) begin
                    $error("int_value: expected %0d, actual %0d", want.value, m_tdata[102:40]);
                    fail_count++;
                end
                if (m_tdata[103] != 1'b0) begin
                    $error("tdata pad: expected 0, actual %b", m_tdata[103]);
                    fail_count++;
                end
                if (m_tlast != want.done) begin
                    $error("done_res: expected %b, actual %b", want.done, m_tlast);
                    fail_count++;
                end
                kind_hits[want.kind]++;
                tokens_checked++;
            end
        end
        m_tready <= !stall_en || ($urandom_range(0, 99) >= 7);
    end

    // run limit
    initial begin
        #(12 * 50_000);
        $display("query_text_tokenizer_unit verification failed");
        $finish;
    end

    // stimulus
    initial begin
        int  i;
        int  rand_bytes;
        bit  paused;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b1;
        lex_reset();

        // hand-picked bytes, typed expectations where obvious
        dir_rows = '{
            '{qtt_pkg::CH_LPAREN, 1'b0, 1'b1,
              make_token(qtt_pkg::K_SPECIAL, 16'd0, 17'd1, qtt_pkg::CH_LPAREN, 63'd0, 1'b0)},
            '{qtt_pkg::CH_SPACE,  1'b0, 1'b0, '0},
            '{"4",                1'b0, 1'b0, '0},
            '{"2",                1'b0, 1'b0, '0},
            '{qtt_pkg::CH_COMMA,  1'b1, 1'b0, '0},
            // lone dot, then halt until the last byte
            '{qtt_pkg::CH_DOT,    1'b0, 1'b0, '0},
            '{qtt_pkg::CH_SPACE,  1'b0, 1'b1,
              make_token(qtt_pkg::K_BADNUM, 16'd0, 17'd1, 8'd0, 63'd0, 1'b0)},
            '{"y",                1'b1, 1'b1,
              make_token(qtt_pkg::K_END, 16'd0, 17'd0, 8'd0, 63'd0, 1'b1)},
            // last byte with no token
            '{qtt_pkg::CH_TAB,    1'b1, 1'b1,
              make_token(qtt_pkg::K_END, 16'd0, 17'd0, 8'd0, 63'd0, 1'b1)},
            // quote as the last byte
            '{qtt_pkg::CH_DQUOTE, 1'b1, 1'b1,
              make_token(qtt_pkg::K_UNTERM, 16'd0, 17'd1, 8'd0, 63'd0, 1'b1)},
            // string with a foreign quote and a high byte inside
            '{qtt_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
            '{8'hFF,              1'b0, 1'b0, '0},
            '{qtt_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
            '{qtt_pkg::CH_SQUOTE, 1'b0, 1'b1,
              make_token(qtt_pkg::K_STRING, 16'd0, 17'd4, 8'd0, 63'd0, 1'b0)},
            // decimal closed by a quote, string left open at the end
            '{"1",                1'b0, 1'b0, '0},
            '{qtt_pkg::CH_DOT,    1'b0, 1'b0, '0},
            '{"5",                1'b0, 1'b0, '0},
            '{qtt_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
            '{"z",                1'b1, 1'b0, '0},
            // high byte word, then a zero integer on the last byte
            '{8'h80,              1'b0, 1'b0, '0},
            '{"9",                1'b0, 1'b0, '0},
            '{qtt_pkg::CH_NL,     1'b0, 1'b0, '0},
            '{qtt_pkg::CH_ZERO,   1'b1, 1'b0, '0},
            '{qtt_pkg::CH_RBRACK, 1'b1, 1'b1,
              make_token(qtt_pkg::K_SPECIAL, 16'd0, 17'd1, qtt_pkg::CH_RBRACK, 63'd0, 1'b1)}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(dir_rows); i++) begin
            send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].tok);
        end

        // random texts, with a quiet stretch in the middle
        rand_bytes = 0;
        paused     = 1'b0;
        while (rand_bytes < RAND_BYTES) begin
            stall_en = !(rand_bytes >= 150 && rand_bytes < 300);
            if ((!paused && rand_bytes >= 225) || $urandom_range(0, 19) == 0) begin
                wait_drained();
                paused = 1'b1;
            end
            build_text();
            send_text();
            rand_bytes += text_q.size();
        end
        stall_en = 1'b1;

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("tokenizer run: %0d bytes in %0d texts, %0d tokens checked",
                 bytes_sent, texts_sent, tokens_checked);
        $display("kinds: word %0d int %0d dec %0d special %0d string %0d bad %0d open %0d end %0d",
                 kind_hits[qtt_pkg::K_WORD], kind_hits[qtt_pkg::K_INT],
                 kind_hits[qtt_pkg::K_DEC], kind_hits[qtt_pkg::K_SPECIAL],
                 kind_hits[qtt_pkg::K_STRING], kind_hits[qtt_pkg::K_BADNUM],
                 kind_hits[qtt_pkg::K_UNTERM], kind_hits[qtt_pkg::K_END]);
        if (fail_count == 0) begin
            $display("query_text_tokenizer_unit verification clean");
        end else begin
            $display("query_text_tokenizer_unit verification failed");
        end
        $finish;
    end

endmodule
